// File: rtl/core/e2c_pkg.sv
package e2c_pkg;

  // working width of the remainder datapath (signed local time fits here)
  localparam int RW = 34;

  localparam int DEFAULT_BASE_YEAR = 2000;
  localparam int EPOCH_YEAR        = 1970;

  localparam int DAY_SECS  = 86400;
  localparam int HOUR_SECS = 3600;
  localparam int MIN_SECS  = 60;
  localparam int WEEK_DAYS = 7;

  // quotient bits produced by each restoring division pass
  localparam int DAY_Q_BITS  = 16;
  localparam int HOUR_Q_BITS = 5;
  localparam int MIN_Q_BITS  = 6;
  localparam int WDAY_Q_BITS = 9;

  localparam int QW = DAY_Q_BITS;
  localparam int CW = $clog2(DAY_Q_BITS);

  localparam logic [3:0] LAST_MONTH = 4'd11;
  localparam logic [3:0] FEBRUARY   = 4'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_DAYS,
    ST_YEAR,
    ST_MONTH,
    ST_HOUR,
    ST_MIN,
    ST_WDAY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        time_ok;
    logic [11:0] calendar_year;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;
    logic [8:0]  day_of_year;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic [2:0]  weekday;
  } res_t;

  // every fourth year is a leap year
  function automatic logic is_leap(input logic [11:0] year);
    return (year[1:0] == 2'b00);
  endfunction

  function automatic logic [RW-1:0] year_days(input logic [11:0] year);
    return is_leap(year) ? RW'(366) : RW'(365);
  endfunction

  function automatic logic [RW-1:0] month_days(input logic [3:0] mon,
                                               input logic [11:0] year);
    logic [4:0] d;
    unique case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                  d = 5'd30;
      4'd1:                                      d = is_leap(year) ? 5'd29 : 5'd28;
      default:                                   d = 5'd31;
    endcase
    return RW'(d);
  endfunction

  function automatic logic [2:0] dow_offset(input logic [3:0] mon);
    logic [2:0] t;
    unique case (mon)
      4'd0:    t = 3'd0;
      4'd1:    t = 3'd3;
      4'd2:    t = 3'd2;
      4'd3:    t = 3'd5;
      4'd4:    t = 3'd0;
      4'd5:    t = 3'd3;
      4'd6:    t = 3'd5;
      4'd7:    t = 3'd1;
      4'd8:    t = 3'd4;
      4'd9:    t = 3'd6;
      4'd10:   t = 3'd2;
      4'd11:   t = 3'd4;
      default: t = 3'd0;
    endcase
    return t;
  endfunction

  // weekday sum before the final mod 7 (years run 1969..2107)
  function automatic logic [RW-1:0] dow_sum(input logic [11:0] year,
                                            input logic [3:0]  mon,
                                            input logic [4:0]  mday);
    logic [11:0] y;
    logic [4:0]  c100;
    logic [2:0]  c400;
    logic [12:0] s;
    y    = (mon <= FEBRUARY) ? (year - 12'd1) : year;
    c100 = (y < 12'd2000) ? 5'd19 : ((y < 12'd2100) ? 5'd20 : 5'd21);
    c400 = (y < 12'd2000) ? 3'd4 : 3'd5;
    s    = {1'b0, y} + {3'b000, y[11:2]} - {8'd0, c100} + {10'd0, c400}
           + {10'd0, dow_offset(mon)} + {8'd0, mday};
    return RW'(s);
  endfunction

  // seconds from 1970 to the start of the base year
  function automatic logic [RW-1:0] base_secs(input int base_year);
    longint s;
    s = 0;
    for (int y = EPOCH_YEAR; y < base_year; y++) begin
      s += ((y % 4) == 0) ? longint'(366 * DAY_SECS) : longint'(365 * DAY_SECS);
    end
    return RW'(s);
  endfunction

endpackage

// File: rtl/core/e2c_cmpsub.sv
module e2c_cmpsub #(
  parameter int W = e2c_pkg::RW
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] ext;

  // a is signed, b is never negative
  assign ext  = {a[W-1], a} - {1'b0, b};
  assign diff = ext[W-1:0];
  assign ge   = ~ext[W];

endmodule

// File: rtl/core/e2c_core.sv
module e2c_core #(
  parameter int BASE_YEAR = e2c_pkg::DEFAULT_BASE_YEAR
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         epoch_seconds,
  input  logic signed [16:0]  zone_offset_seconds,
  output logic                idle,
  output logic                res_valid,
  input  logic                res_ready,
  output e2c_pkg::res_t       res
);
  import e2c_pkg::*;

  localparam logic [RW-1:0] BASE_SECS = base_secs(BASE_YEAR);
  localparam logic [RW-1:0] DAY_DVS   = RW'(DAY_SECS) << (DAY_Q_BITS - 1);
  localparam logic [RW-1:0] HOUR_DVS  = RW'(HOUR_SECS) << (HOUR_Q_BITS - 1);
  localparam logic [RW-1:0] MIN_DVS   = RW'(MIN_SECS) << (MIN_Q_BITS - 1);
  localparam logic [RW-1:0] WDAY_DVS  = RW'(WEEK_DAYS) << (WDAY_Q_BITS - 1);

  state_t          state, state_next;
  logic [RW-1:0]   r, r_next;
  logic [RW-1:0]   dvs, dvs_next;
  logic [QW-1:0]   q, q_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic [16:0]     sod, sod_next;
  res_t            res_next;

  logic [RW-1:0]   op_b;
  logic [RW-1:0]   diff;
  logic            ge;
  logic [RW-1:0]   rem_step;
  logic            last_step;

  // shared compare-subtract unit
  e2c_cmpsub #(.W(RW)) u_cmpsub (
    .a    (r),
    .b    (op_b),
    .diff (diff),
    .ge   (ge)
  );

  // operand select for the shared unit
  always_comb begin
    unique case (state)
      ST_BASE:                            op_b = BASE_SECS;
      ST_DAYS, ST_HOUR, ST_MIN, ST_WDAY:  op_b = dvs;
      ST_YEAR:                            op_b = year_days(res.calendar_year);
      ST_MONTH:  op_b = month_days(res.month_index, res.calendar_year);
      default:                            op_b = '0;
    endcase
  end

  assign rem_step  = ge ? diff : r;
  assign last_step = (cnt == '0);

  // sequencer
  always_comb begin
    state_next = state;
    r_next     = r;
    dvs_next   = dvs;
    q_next     = q;
    cnt_next   = cnt;
    sod_next   = sod;
    res_next   = res;
    idle       = 1'b0;
    res_valid  = 1'b0;

    // one restoring division step, used by the divide states
    if (state == ST_DAYS || state == ST_HOUR || state == ST_MIN || state == ST_WDAY) begin
      r_next   = rem_step;
      q_next   = {q[QW-2:0], ge};
      dvs_next = dvs >> 1;
      cnt_next = cnt - 1'b1;
    end

    unique case (state)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          r_next     = {2'b00, epoch_seconds}
                       + {{(RW - 17){zone_offset_seconds[16]}}, zone_offset_seconds};
          res_next   = '0;
          state_next = ST_BASE;
        end
      end
      ST_BASE: begin
        if (ge) begin
          r_next                 = diff;
          dvs_next               = DAY_DVS;
          cnt_next               = CW'(DAY_Q_BITS - 1);
          q_next                 = '0;
          res_next.time_ok       = 1'b1;
          res_next.calendar_year = 12'(BASE_YEAR);
          state_next             = ST_DAYS;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DAYS: begin
        if (last_step) begin
          r_next     = RW'(q_next);
          sod_next   = rem_step[16:0];
          state_next = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (ge) begin
          r_next                 = diff;
          res_next.calendar_year = res.calendar_year + 12'd1;
        end else begin
          res_next.day_of_year = r[8:0];
          state_next           = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (ge && res.month_index != LAST_MONTH) begin
          r_next               = diff;
          res_next.month_index = res.month_index + 4'd1;
        end else begin
          res_next.day_of_month = r[4:0] + 5'd1;
          r_next                = RW'(sod);
          dvs_next              = HOUR_DVS;
          cnt_next              = CW'(HOUR_Q_BITS - 1);
          q_next                = '0;
          state_next            = ST_HOUR;
        end
      end
      ST_HOUR: begin
        if (last_step) begin
          res_next.hour_of_day = q_next[HOUR_Q_BITS-1:0];
          dvs_next             = MIN_DVS;
          cnt_next             = CW'(MIN_Q_BITS - 1);
          q_next               = '0;
          state_next           = ST_MIN;
        end
      end
      ST_MIN: begin
        if (last_step) begin
          res_next.minute_of_hour   = q_next[MIN_Q_BITS-1:0];
          res_next.second_of_minute = rem_step[5:0];
          r_next     = dow_sum(res.calendar_year, res.month_index, res.day_of_month);
          dvs_next   = WDAY_DVS;
          cnt_next   = CW'(WDAY_Q_BITS - 1);
          q_next     = '0;
          state_next = ST_WDAY;
        end
      end
      ST_WDAY: begin
        if (last_step) begin
          res_next.weekday = rem_step[2:0];
          state_next       = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    r   <= r_next;
    dvs <= dvs_next;
    q   <= q_next;
    cnt <= cnt_next;
    sod <= sod_next;
    res <= res_next;
  end

endmodule

// File: rtl/core/epoch_seconds_to_calendar.sv
// Local calendar date and time from a 32-bit count of seconds since 1970.
// Input channel s_axis: one beat carries the epoch seconds count. Output
// channel m_axis: one beat per input beat, tuser is the valid flag (local
// time at or after the start of BASE_YEAR), tdata the calendar fields;
// when the flag is low every tdata field is zero.
// zone_offset_seconds is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle; the block does not enforce
// this. It is added to every epoch count. Reset value is 0. A single
// compare-subtract unit runs each beat: a 16-step day split, one step per
// elapsed year, one per month (up to 12), then 5, 6 and 9 restoring steps
// for hour, minute and weekday; a time before the base year skips them all.
// s_axis_tready is high only while the sequencer is idle. The finished
// result moves into an output register, so a new beat can be taken while
// the previous result waits; a stalled receiver holds m_axis steady and
// the sequencer waits in its final state until the register frees up.
// Reset (rst, synchronous) empties the pipeline and clears the offset.
module epoch_seconds_to_calendar #(
  parameter int BASE_YEAR = e2c_pkg::DEFAULT_BASE_YEAR
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,    // zone_offset_seconds, signed
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // epoch_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] calendar_year, [15:12] month_index, [20:16] day_of_month,
  // [29:21] day_of_year, [34:30] hour_of_day, [40:35] minute_of_hour,
  // [46:41] second_of_minute, [49:47] weekday, [55:50] zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser    // time_ok
);
  import e2c_pkg::*;

  logic signed [16:0] zone_offset_seconds;
  logic               core_idle;
  logic               res_valid;
  logic               res_ready;
  res_t               core_res;
  res_t               out_res;
  logic               out_valid;

  // offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset_seconds <= '0;
    end else if (cfg_wr_en) begin
      zone_offset_seconds <= cfg_wr_data;
    end
  end

  e2c_core #(.BASE_YEAR(BASE_YEAR)) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .start               (s_axis_tvalid & core_idle),
    .epoch_seconds       (s_axis_tdata),
    .zone_offset_seconds (zone_offset_seconds),
    .idle                (core_idle),
    .res_valid           (res_valid),
    .res_ready           (res_ready),
    .res                 (core_res)
  );

  assign s_axis_tready = core_idle;
  assign res_ready     = ~out_valid | m_axis_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.time_ok;
  assign m_axis_tdata  = {6'd0, out_res.weekday, out_res.second_of_minute,
                          out_res.minute_of_hour, out_res.hour_of_day,
                          out_res.day_of_year, out_res.day_of_month,
                          out_res.month_index, out_res.calendar_year};

  // the sequencer never takes a beat while holding a finished result
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !res_valid)
    else $error("sequencer idle with a pending result");

  // a taken beat makes the sequencer busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sequencer still idle after taking a beat");

  // an invalid time carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid result with nonzero fields");

  // valid results lie in their calendar ranges
  a_fields_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      out_res.month_index <= 4'd11 && out_res.day_of_month != 5'd0 &&
      out_res.hour_of_day <= 5'd23 && out_res.minute_of_hour <= 6'd59 &&
      out_res.second_of_minute <= 6'd59 && out_res.weekday <= 3'd6)
    else $error("result field out of range");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int BASE_YEAR    = e2c_pkg::DEFAULT_BASE_YEAR;
  localparam int EPOCH_YEAR   = e2c_pkg::EPOCH_YEAR;
  localparam int DAY_SECS     = e2c_pkg::DAY_SECS;
  localparam int RAND_PER_SEG = 242;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_CYCLES = 1500000;

  // expected result, laid out as {tuser, tdata} from the top bit down
  typedef struct packed {
    logic        ok;
    logic [5:0]  pad;
    logic [2:0]  wday;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [8:0]  yday;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [11:0] year;
  } civil_time_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic [31:0]        epoch_q[$];
  civil_time_t        civil_expected_q[$];
  logic signed [16:0] zone_offset = '0;
  int                 sender_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 inputs_accepted = 0;
  int                 hold_at = 32'h7fffffff;
  int                 hold_left = 0;
  bit                 hold_taken = 1'b0;
  int                 mismatches = 0;
  int                 cycle_count = 0;

  epoch_seconds_to_calendar uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // calendar arithmetic: every fourth year is a leap year
  function automatic int days_in_year(input int y);
    return (y % 4 == 0) ? 366 : 365;
  endfunction

  function automatic int days_in_month(input int m, input int y);
    case (m)
      1:           return (y % 4 == 0) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic int month_shift(input int m);
    case (m)
      0, 4:   return 0;
      1, 5:   return 3;
      2, 10:  return 2;
      3, 6:   return 5;
      7:      return 1;
      8, 11:  return 4;
      default: return 6;
    endcase
  endfunction

  // seconds from 1970 to the first second of year y
  function automatic longint year_start(input int y);
    longint s;
    s = 0;
    for (int k = EPOCH_YEAR; k < y; k++) s += longint'(days_in_year(k)) * DAY_SECS;
    return s;
  endfunction

  // local seconds since 1970 of a calendar date (month from 0, day from 1)
  function automatic longint civil_secs(input int y, input int m, input int d,
                                        input int sec_of_day);
    longint s;
    s = year_start(y);
    for (int k = 0; k < m; k++) s += longint'(days_in_month(k, y)) * DAY_SECS;
    return s + longint'(d - 1) * DAY_SECS + sec_of_day;
  endfunction

  // epoch count plus zone offset split into calendar fields
  function automatic civil_time_t predict_civil(input logic [31:0] epoch,
                                                input logic signed [16:0] zone);
    civil_time_t c;
    longint      t;
    longint      rem;
    int          y;
    int          m;
    int          md;
    int          ys;
    c = '0;
    t = longint'(epoch) + longint'(zone);
    if (t < year_start(BASE_YEAR)) return c;
    rem = t - year_start(BASE_YEAR);
    y = BASE_YEAR;
    while (rem >= longint'(days_in_year(y)) * DAY_SECS) begin
      rem -= longint'(days_in_year(y)) * DAY_SECS;
      y++;
    end
    c.yday = 9'(rem / DAY_SECS);
    m = 0;
    while (m < 11 && rem >= longint'(days_in_month(m, y)) * DAY_SECS) begin
      rem -= longint'(days_in_month(m, y)) * DAY_SECS;
      m++;
    end
    md = int'(rem / DAY_SECS) + 1;
    rem = rem % DAY_SECS;
    c.ok     = 1'b1;
    c.year   = 12'(y);
    c.month  = 4'(m);
    c.mday   = 5'(md);
    c.hour   = 5'(rem / 3600);
    c.minute = 6'((rem % 3600) / 60);
    c.second = 6'(rem % 60);
    // january and february count with the previous year
    ys = (m < 2) ? y - 1 : y;
    c.wday = 3'((ys + ys / 4 - ys / 100 + ys / 400 + month_shift(m) + md) % 7);
    return c;
  endfunction

  // random epoch: mostly aimed at year, month and day edges in local time
  function automatic logic [31:0] random_epoch();
    int     sel;
    int     y;
    int     m;
    int     d;
    int     sod;
    longint target;
    longint e;
    sel = $urandom_range(99);
    if (sel < 25) return $urandom();
    if (sel < 35) return $urandom_range(0, 1000000000);
    if (sel < 45) begin
      target = year_start(BASE_YEAR) + longint'($urandom_range(0, 8)) - 4;
    end else begin
      y = $urandom_range(BASE_YEAR, 2106);
      m = $urandom_range(0, 11);
      case ($urandom_range(2))
        0:       d = 1;
        1:       d = days_in_month(m, y);
        default: d = $urandom_range(1, days_in_month(m, y));
      endcase
      case ($urandom_range(2))
        0:       sod = $urandom_range(0, 2);
        1:       sod = DAY_SECS - 1 - $urandom_range(0, 2);
        default: sod = $urandom_range(0, DAY_SECS - 1);
      endcase
      target = civil_secs(y, m, d, sod);
    end
    e = target - longint'(zone_offset);
    if (e < 0 || e > 64'hffffffff) return $urandom();
    return e[31:0];
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // wait until no beat is queued, in flight or owed by the block
  task automatic settle();
    while (epoch_q.size() != 0 || s_axis_tvalid || civil_expected_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_zone(input logic signed [16:0] z);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= z;
    zone_offset = z;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // input driver: holds a beat until taken, idles at random between beats
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        civil_expected_q.push_back(predict_civil(s_axis_tdata, zone_offset));
        inputs_accepted <= inputs_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (epoch_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_axis_tdata  <= epoch_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, armed once by the stimulus
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_taken && inputs_accepted >= hold_at) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: compare each beat with the oldest expectation
  always @(posedge clk) begin
    civil_time_t seen;
    civil_time_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = {m_axis_tuser, m_axis_tdata};
        if (civil_expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual %h", $time, seen);
          mismatches++;
        end else begin
          want = civil_expected_q.pop_front();
          check_field("time_ok", want.ok, seen.ok);
          check_field("calendar_year", want.year, seen.year);
          check_field("month_index", want.month, seen.month);
          check_field("day_of_month", want.mday, seen.mday);
          check_field("day_of_year", want.yday, seen.yday);
          check_field("hour_of_day", want.hour, seen.hour);
          check_field("minute_of_hour", want.minute, seen.minute);
          check_field("second_of_minute", want.second, seen.second);
          check_field("weekday", want.wday, seen.wday);
          check_field("tdata padding", want.pad, seen.pad);
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic signed [16:0] z;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    sender_idle_pct = 25;
    recv_idle_pct   = 86;

    // reset offset: base year edge, leap days, last day of year, field extremes
    set_zone(17'sd0);
    epoch_q.push_back(32'd0);
    epoch_q.push_back(32'(year_start(BASE_YEAR) - 1));
    epoch_q.push_back(32'(year_start(BASE_YEAR)));
    epoch_q.push_back(32'(civil_secs(2000, 1, 29, 0)));
    epoch_q.push_back(32'(civil_secs(2000, 11, 31, DAY_SECS - 1)));
    epoch_q.push_back(32'(civil_secs(2100, 1, 29, 43200)));
    epoch_q.push_back(32'(civil_secs(2100, 2, 1, 0)));
    epoch_q.push_back(32'hffffffff);
    epoch_q.push_back(32'h80000000);
    epoch_q.push_back(32'h7fffffff);
    epoch_q.push_back(32'haaaaaaaa);
    epoch_q.push_back(32'h55555555);

    // largest positive offset: sum runs past 32 bits into 2106
    settle();
    set_zone(17'sd50400);
    epoch_q.push_back(32'(year_start(BASE_YEAR) - 50400));
    epoch_q.push_back(32'(year_start(BASE_YEAR) - 50401));
    epoch_q.push_back(32'hffffffff);
    epoch_q.push_back(32'd0);

    // largest negative offset
    settle();
    set_zone(-17'sd50400);
    epoch_q.push_back(32'(year_start(BASE_YEAR) + 50399));
    epoch_q.push_back(32'(year_start(BASE_YEAR) + 50400));
    epoch_q.push_back(32'(civil_secs(2001, 0, 1, 0) + 50400));

    // offsets beyond the nominal range, both 17-bit extremes
    settle();
    set_zone(17'sh0ffff);
    epoch_q.push_back(32'hffffffff);
    epoch_q.push_back(32'(year_start(BASE_YEAR) - 65535));
    settle();
    set_zone(17'sh10000);
    epoch_q.push_back(32'(year_start(BASE_YEAR) + 65535));
    epoch_q.push_back(32'(year_start(BASE_YEAR) + 65536));

    // random segments, one offset each, idling pattern changes every two
    for (int seg = 0; seg < 6; seg++) begin
      settle();
      case (seg)
        0:       z = 17'sd0;
        2:       z = 17'sd50400;
        3:       z = -17'sd50400;
        5:       z = 17'sh10000;
        default: z = 17'(int'($urandom_range(0, 100800)) - 50400);
      endcase
      set_zone(z);
      if (seg < 2) begin
        sender_idle_pct = 25;
        recv_idle_pct   = 86;
      end else if (seg < 4) begin
        sender_idle_pct = 86;
        recv_idle_pct   = 25;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      if (seg == 4) hold_at = inputs_accepted + 40;
      for (int i = 0; i < RAND_PER_SEG; i++) epoch_q.push_back(random_epoch());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && civil_expected_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
